// ===== rtl/aei_pkg.sv =====
package aei_pkg;

  localparam int GEN_BITS_DEFAULT   = 32;
  localparam int COUNT_BITS_DEFAULT = 32;

  typedef enum logic [3:0] {
    CAUSE_BOOT      = 4'd0,
    CAUSE_FAULT     = 4'd1,
    CAUSE_REMOTE    = 4'd2,
    CAUSE_LINK      = 4'd3,
    CAUSE_CONTROL   = 4'd4,
    CAUSE_MB_ABSENT = 4'd5,
    CAUSE_MB_BAD    = 4'd6,
    CAUSE_WAIT      = 4'd7,
    CAUSE_ENABLED   = 4'd8
  } cause_t;

  typedef struct packed {
    logic        actuator_ready;
    logic        fault_active;
    logic        stop_latched;
    logic        link_up;
    logic        command_valid;
    logic        mailbox_present;
    logic        mailbox_good;
    logic [31:0] generation;
  } snap_t;

  typedef struct packed {
    logic        enable;
    cause_t      cause;
    logic [31:0] generation_echo;
    logic [31:0] accepted_number;
    logic        awaiting_fresh;
    logic [31:0] change_count;
  } verdict_t;

endpackage

// ===== rtl/actuator_enable_interlock.sv =====
// Actuator enable interlock. Each status snapshot request on the snap channel
// yields exactly one verdict on the verdict channel, in order. A snapshot is
// taken into an input register, judged against the interlock state (fresh
// requirement, blocked and accepted generations, last cause, change counter)
// by a flag priority decode and one generation compare, and the verdict lands
// in a result register, valid once its snapshot has moved on from the input
// register. Throughput is one snapshot per cycle unless the verdict stalls,
// set by the single judging pass that also commits the state update. A stalled
// verdict holds the input register; snap_stall rises only when both are full.
module actuator_enable_interlock #(
  parameter int GEN_BITS   = aei_pkg::GEN_BITS_DEFAULT,
  parameter int COUNT_BITS = aei_pkg::COUNT_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              snap_valid,
  output logic              snap_stall,
  input  aei_pkg::snap_t    snap,
  output logic              verdict_valid,
  input  logic              verdict_stall,
  output aei_pkg::verdict_t verdict
);

  logic                   hold_valid;
  aei_pkg::snap_t         hold;
  logic                   advance;

  logic                   fresh_required;
  logic [GEN_BITS-1:0]    blocked_number;
  logic [GEN_BITS-1:0]    accepted_store;
  aei_pkg::cause_t        previous_cause;
  logic [COUNT_BITS-1:0]  change_counter;

  logic                   fresh_required_next;
  logic [GEN_BITS-1:0]    blocked_number_next;
  logic [GEN_BITS-1:0]    accepted_store_next;
  aei_pkg::cause_t        previous_cause_next;
  logic [COUNT_BITS-1:0]  change_counter_next;
  aei_pkg::verdict_t      verdict_next;

  assign advance    = hold_valid && (!verdict_valid || !verdict_stall);
  assign snap_stall = hold_valid && !advance;

  aei_judge #(
    .GEN_BITS   (GEN_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_judge (
    .snap                (hold),
    .fresh_required      (fresh_required),
    .blocked_number      (blocked_number),
    .accepted_store      (accepted_store),
    .previous_cause      (previous_cause),
    .change_counter      (change_counter),
    .fresh_required_next (fresh_required_next),
    .blocked_number_next (blocked_number_next),
    .accepted_store_next (accepted_store_next),
    .previous_cause_next (previous_cause_next),
    .change_counter_next (change_counter_next),
    .verdict             (verdict_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!snap_stall) begin
      hold_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!snap_stall && snap_valid) begin
      hold <= snap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (advance) begin
      verdict_valid <= 1'b1;
    end else if (!verdict_stall) begin
      verdict_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      verdict <= verdict_next;
    end
  end

  // interlock state commits once per judged snapshot
  always_ff @(posedge clk) begin
    if (rst) begin
      fresh_required <= 1'b1;
      blocked_number <= '0;
      accepted_store <= '0;
      previous_cause <= aei_pkg::CAUSE_BOOT;
      change_counter <= '0;
    end else if (advance) begin
      fresh_required <= fresh_required_next;
      blocked_number <= blocked_number_next;
      accepted_store <= accepted_store_next;
      previous_cause <= previous_cause_next;
      change_counter <= change_counter_next;
    end
  end

endmodule

// ===== rtl/aei_judge.sv =====
module aei_judge #(
  parameter int GEN_BITS   = aei_pkg::GEN_BITS_DEFAULT,
  parameter int COUNT_BITS = aei_pkg::COUNT_BITS_DEFAULT
) (
  input  aei_pkg::snap_t          snap,
  input  logic                    fresh_required,
  input  logic [GEN_BITS-1:0]     blocked_number,
  input  logic [GEN_BITS-1:0]     accepted_store,
  input  aei_pkg::cause_t         previous_cause,
  input  logic [COUNT_BITS-1:0]   change_counter,
  output logic                    fresh_required_next,
  output logic [GEN_BITS-1:0]     blocked_number_next,
  output logic [GEN_BITS-1:0]     accepted_store_next,
  output aei_pkg::cause_t         previous_cause_next,
  output logic [COUNT_BITS-1:0]   change_counter_next,
  output aei_pkg::verdict_t       verdict
);

  logic [63:0]           gen_wide;
  logic [GEN_BITS-1:0]   gen;
  logic [63:0]           gen_kept;
  aei_pkg::cause_t       base_cause;
  aei_pkg::cause_t       cause;
  logic                  enable;
  logic [63:0]           acc_wide;
  logic [63:0]           cnt_wide;

  // generations are kept modulo 2^GEN_BITS
  assign gen_wide = 64'(snap.generation);
  assign gen      = gen_wide[GEN_BITS-1:0];
  assign gen_kept = 64'(gen);

  always_comb begin
    priority if (!snap.actuator_ready) begin
      base_cause = aei_pkg::CAUSE_BOOT;
    end else if (snap.fault_active) begin
      base_cause = aei_pkg::CAUSE_FAULT;
    end else if (snap.stop_latched) begin
      base_cause = aei_pkg::CAUSE_REMOTE;
    end else if (!snap.link_up) begin
      base_cause = aei_pkg::CAUSE_LINK;
    end else if (!snap.command_valid) begin
      base_cause = aei_pkg::CAUSE_CONTROL;
    end else if (!snap.mailbox_present) begin
      base_cause = aei_pkg::CAUSE_MB_ABSENT;
    end else if (!snap.mailbox_good) begin
      base_cause = aei_pkg::CAUSE_MB_BAD;
    end else begin
      base_cause = aei_pkg::CAUSE_ENABLED;
    end
  end

  always_comb begin
    cause               = base_cause;
    enable              = 1'b0;
    fresh_required_next = fresh_required;
    blocked_number_next = blocked_number;
    accepted_store_next = accepted_store;
    if (base_cause != aei_pkg::CAUSE_ENABLED) begin
      fresh_required_next = 1'b1;
      // zero generation is never recorded as blocked
      if (snap.mailbox_present && (gen != '0)) begin
        blocked_number_next = gen;
      end
    end else if (fresh_required && (gen == blocked_number)) begin
      cause = aei_pkg::CAUSE_WAIT;
    end else begin
      fresh_required_next = 1'b0;
      accepted_store_next = gen;
      enable              = 1'b1;
    end
  end

  always_comb begin
    previous_cause_next = cause;
    if (cause != previous_cause) begin
      change_counter_next = change_counter + COUNT_BITS'(1);
    end else begin
      change_counter_next = change_counter;
    end
  end

  assign acc_wide = 64'(accepted_store_next);
  assign cnt_wide = 64'(change_counter_next);

  always_comb begin
    verdict.enable          = enable;
    verdict.cause           = cause;
    verdict.generation_echo = gen_kept[31:0];
    verdict.accepted_number = acc_wide[31:0];
    verdict.awaiting_fresh  = fresh_required_next;
    verdict.change_count    = cnt_wide[31:0];
  end

endmodule

// ===== rtl/aei_checker.sv =====
module aei_checker (
  input logic              clk,
  input logic              rst,
  input logic              snap_valid,
  input logic              snap_stall,
  input logic              verdict_valid,
  input logic              verdict_stall,
  input aei_pkg::verdict_t verdict
);

  // a stalled verdict stays put
  a_verdict_hold: assert property (@(posedge clk) disable iff (rst)
    verdict_valid && verdict_stall |=> verdict_valid && $stable(verdict))
    else $error("verdict changed while stalled");

  // the input side only backs up behind a stalled verdict
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    snap_valid && snap_stall |-> verdict_valid && verdict_stall)
    else $error("request stalled without a stalled verdict");

  a_enable_cause: assert property (@(posedge clk) disable iff (rst)
    verdict_valid |-> (verdict.enable == (verdict.cause == aei_pkg::CAUSE_ENABLED)))
    else $error("enable disagrees with cause");

  a_enable_accepts: assert property (@(posedge clk) disable iff (rst)
    verdict_valid && verdict.enable |->
      !verdict.awaiting_fresh && (verdict.accepted_number == verdict.generation_echo))
    else $error("enabled verdict did not accept its generation");

  // every block, wait-fresh included, leaves the fresh requirement set
  a_block_needs_fresh: assert property (@(posedge clk) disable iff (rst)
    verdict_valid && !verdict.enable |-> verdict.awaiting_fresh)
    else $error("blocked verdict without fresh requirement");

endmodule

bind actuator_enable_interlock aei_checker u_aei_checker (
  .clk           (clk),
  .rst           (rst),
  .snap_valid    (snap_valid),
  .snap_stall    (snap_stall),
  .verdict_valid (verdict_valid),
  .verdict_stall (verdict_stall),
  .verdict       (verdict)
);
